/* rtl/tkmm_pkg.sv */
// Package with the shared types and constants of the multichannel top-k tracker.
package tkmm_pkg;

    localparam int VAL_W = 16;
    localparam int SUM_W = 48;
    localparam int FP_W  = 24;
    localparam int QUO_W = 16;

    localparam logic [FP_W-1:0]  FP_RESET  = 24'd2272640;
    localparam logic [VAL_W-1:0] MAX_RESET = 16'h0000;
    localparam logic [VAL_W-1:0] MIN_RESET = 16'hFFFF;
    localparam logic [SUM_W-1:0] SUM_MAX   = 48'hFFFF_FFFF_FFFF;

    localparam logic [1:0] FUNC_ADD   = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [VAL_W-1:0] max_val;
        logic [VAL_W-1:0] min_val;
        logic             max_ahead;
        logic             min_ahead;
    } t_link;

    typedef struct packed {
        logic [VAL_W-1:0] max_val;
        logic [VAL_W-1:0] min_val;
    } t_rd;

    localparam t_link LINK_NONE = '{max_val: '0, min_val: '0, max_ahead: 1'b0, min_ahead: 1'b0};

endpackage

/* rtl/multichannel_topk_min_max_mean.sv */
// Top level of the multichannel top-k max/min tracker with running mean.
//
// Each slave transaction is an add, a read or a clear. In an add, a row of
// RANKS cells compares the sample with its own entry and its left neighbor's
// in parallel and shifts in one step, and a clear restores all entries at
// once. A read captures the channel's entries into the cells' read registers,
// runs a bit-serial divider for the mean and then shifts the ranked items out
// at one per cycle while the output is not stalled; the block takes no new
// transaction until the last item is out.
// Configuration writes set the mean divisor frame_pixels.
module multichannel_topk_min_max_mean
    import tkmm_pkg::*;
#(
    parameter int CHANNELS = 8,
    parameter int RANKS    = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [FP_W-1:0]   i_cfg_wdata,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    // channel[2:0], sample[18:3], zero pad[23:19]
    input  logic [23:0]       i_s_tdata,
    // func[1:0]
    input  logic [1:0]        i_s_tuser,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    // out_channel[2:0], rank[6:3], max_value[22:7], min_value[38:23], mean[54:39], pad[55]
    output logic [55:0]       o_m_tdata,
    output logic              o_m_tlast
);

    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CHX_W = (CH_W > 3) ? CH_W : 3;
    localparam int RK_W  = (RANKS > 1) ? $clog2(RANKS) : 1;
    localparam int RKX_W = (RK_W > 4) ? RK_W : 4;

    t_state r_state;
    t_state n_state;

    logic [FP_W-1:0]  r_fp;
    logic [SUM_W-1:0] r_sum [CHANNELS];
    logic [2:0]       r_ch;
    logic [RK_W-1:0]  r_rank;
    logic [QUO_W-1:0] r_mean;
    logic             r_m_tvalid;
    logic [55:0]      r_m_tdata;
    logic             r_m_tlast;

    logic [1:0]       w_func;
    logic [2:0]       w_ch;
    logic [VAL_W-1:0] w_sample;
    logic [CHX_W-1:0] w_ch_ext;
    logic [CH_W-1:0]  w_ch_idx;
    logic             w_ch_ok;
    logic             w_accept;
    logic             w_ins;
    logic             w_load;
    logic             w_clear;
    logic             w_ready;
    logic             w_emit;
    logic             w_last;
    logic [SUM_W:0]   w_sum_add;
    logic             w_div_done;
    logic [QUO_W-1:0] w_quot;
    logic [RKX_W-1:0] w_rank_ext;

    t_link w_link [RANKS];
    t_rd   w_rd   [RANKS];

    assign w_func   = i_s_tuser;
    assign w_ch     = i_s_tdata[2:0];
    assign w_sample = i_s_tdata[18:3];
    assign w_ch_ext = CHX_W'(w_ch);
    assign w_ch_idx = w_ch_ext[CH_W-1:0];
    assign w_ch_ok  = 32'(w_ch) < CHANNELS;
    assign w_accept = i_s_tvalid && w_ready;

    always_comb begin
        w_ins   = 1'b0;
        w_load  = 1'b0;
        w_clear = 1'b0;
        case (w_func)
            FUNC_ADD:   w_ins   = w_accept && w_ch_ok;
            FUNC_READ:  w_load  = w_accept && w_ch_ok;
            FUNC_CLEAR: w_clear = w_accept;
            default:    w_ins   = 1'b0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (w_load) n_state = ST_DIV;
            ST_DIV:  if (w_div_done) n_state = ST_EMIT;
            ST_EMIT: if (w_emit && w_last) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_ready = 1'b0;
        w_emit  = 1'b0;
        case (r_state)
            ST_IDLE: w_ready = 1'b1;
            ST_DIV:  w_ready = 1'b0;
            ST_EMIT: w_emit  = !r_m_tvalid || i_m_tready;
            default: w_ready = 1'b0;
        endcase
    end

    assign w_last     = r_rank == RK_W'(RANKS - 1);
    assign w_rank_ext = RKX_W'(r_rank);
    assign w_sum_add  = {1'b0, r_sum[w_ch_idx]} + (SUM_W + 1)'(w_sample);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_fp       <= FP_RESET;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_fp <= i_cfg_wdata;
            end
            if (w_emit) begin
                r_m_tvalid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_clear) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_sum[c] <= '0;
            end
        end else if (w_ins) begin
            r_sum[w_ch_idx] <= w_sum_add[SUM_W] ? SUM_MAX : w_sum_add[SUM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_ch   <= w_ch;
            r_rank <= '0;
        end else if (w_emit) begin
            r_rank <= r_rank + RK_W'(1);
        end
        if (w_div_done) begin
            r_mean <= w_quot;
        end
        if (w_emit) begin
            r_m_tdata <= {1'b0, r_mean, w_rd[0].min_val, w_rd[0].max_val,
                          w_rank_ext[3:0], r_ch};
            r_m_tlast <= w_last;
        end
    end

    for (genvar k = 0; k < RANKS; k++) begin : g_cell
        tkmm_cell #(
            .CHANNELS (CHANNELS)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_clear   (w_clear),
            .i_ins     (w_ins),
            .i_load    (w_load),
            .i_shift   (w_emit),
            .i_ch      (w_ch_idx),
            .i_sample  (w_sample),
            .i_prev    ((k == 0) ? LINK_NONE : w_link[(k == 0) ? 0 : k - 1]),
            .o_link    (w_link[k]),
            .i_rd_next (w_rd[(k == RANKS - 1) ? k : k + 1]),
            .o_rd      (w_rd[k])
        );
    end

    tkmm_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_load),
        .i_sum     (r_sum[w_ch_idx]),
        .i_divisor (r_fp),
        .o_done    (w_div_done),
        .o_quot    (w_quot)
    );

    assign o_s_tready = w_ready;
    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tlast  = r_m_tlast;

endmodule

/* rtl/tkmm_cell.sv */
// One rank cell: holds the max and min entries of one rank for every channel.
module tkmm_cell
    import tkmm_pkg::*;
#(
    parameter int CHANNELS = 8,
    localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_clear,
    input  logic                  i_ins,
    input  logic                  i_load,
    input  logic                  i_shift,
    input  logic [CH_W-1:0]       i_ch,
    input  logic [VAL_W-1:0]      i_sample,
    input  t_link                 i_prev,
    output t_link                 o_link,
    input  t_rd                   i_rd_next,
    output t_rd                   o_rd
);

    logic [VAL_W-1:0] r_max [CHANNELS];
    logic [VAL_W-1:0] r_min [CHANNELS];
    t_rd              r_rd;

    logic [VAL_W-1:0] w_cur_max;
    logic [VAL_W-1:0] w_cur_min;
    logic             w_max_ahead;
    logic             w_min_ahead;
    logic [VAL_W-1:0] n_max;
    logic [VAL_W-1:0] n_min;

    always_comb begin
        w_cur_max   = r_max[i_ch];
        w_cur_min   = r_min[i_ch];
        w_max_ahead = i_sample > w_cur_max;
        w_min_ahead = i_sample < w_cur_min;
        n_max = w_max_ahead ? (i_prev.max_ahead ? i_prev.max_val : i_sample) : w_cur_max;
        n_min = w_min_ahead ? (i_prev.min_ahead ? i_prev.min_val : i_sample) : w_cur_min;
        o_link.max_val   = w_cur_max;
        o_link.min_val   = w_cur_min;
        o_link.max_ahead = w_max_ahead;
        o_link.min_ahead = w_min_ahead;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_max[c] <= MAX_RESET;
                r_min[c] <= MIN_RESET;
            end
        end else if (i_ins) begin
            r_max[i_ch] <= n_max;
            r_min[i_ch] <= n_min;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rd.max_val <= w_cur_max;
            r_rd.min_val <= w_cur_min;
        end else if (i_shift) begin
            r_rd <= i_rd_next;
        end
    end

    assign o_rd = r_rd;

endmodule

/* rtl/tkmm_div.sv */
// Bit-serial divider that forms the saturated 16-bit mean of a channel sum.
module tkmm_div
    import tkmm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SUM_W-1:0]  i_sum,
    input  logic [FP_W-1:0]   i_divisor,
    output logic              o_done,
    output logic [QUO_W-1:0]  o_quot
);

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_sat;
    logic [FP_W-1:0]    r_rem;
    logic [QUO_W-1:0]   r_low;
    logic [FP_W-1:0]    r_div;

    logic [FP_W:0]      w_trial;
    logic [FP_W:0]      w_diff;
    logic               w_ge;
    logic               w_sat;

    always_comb begin
        w_trial = {r_rem, r_low[QUO_W-1]};
        w_diff  = w_trial - {1'b0, r_div};
        w_ge    = w_trial >= {1'b0, r_div};
        w_sat   = i_sum >= SUM_W'({i_divisor, {QUO_W{1'b0}}});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(QUO_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sat <= w_sat;
            r_div <= i_divisor;
            r_rem <= i_sum[QUO_W+FP_W-1:QUO_W];
            r_low <= i_sum[QUO_W-1:0];
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[FP_W-1:0] : w_trial[FP_W-1:0];
            r_low <= {r_low[QUO_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_sat ? {QUO_W{1'b1}} : r_low;

endmodule
